// ===== design/fpr_pkg.sv =====
package fpr_pkg;

  localparam int FREQ_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int STATUS_W   = 3;
  localparam int WIDX_W     = 3;
  localparam int WORD_W     = 32;

  // datapath widths
  localparam int FS_W   = 39;  // target shifted by output divider select
  localparam int PN_W   = 29;  // reference times doubler
  localparam int PD_W   = 11;  // R times div2
  localparam int VAL_W  = 29;  // remainder, modulus, frac
  localparam int NINT_W = 50;

  // serial units
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 32;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 36;
  localparam int GCD_W  = 29;

  localparam logic [FREQ_W-1:0] MIN_FREQ_DEF = 32'd35000000;
  localparam logic [FS_W-1:0]   LO_RATIO     = 39'd2200000000;
  localparam logic [FS_W-1:0]   PRESCALE_LIM = 39'd3600000000;
  localparam logic [2:0]        SEL_MAX      = 3'd6;
  localparam logic [VAL_W-1:0]  MOD_MIN      = 29'd2;
  localparam logic [VAL_W-1:0]  MOD_MAX      = 29'd4095;
  localparam logic [NINT_W-1:0] N_MAX        = 50'd65535;
  localparam logic [NINT_W-1:0] N_MIN_P0     = 50'd23;
  localparam logic [NINT_W-1:0] N_MIN_P1     = 50'd75;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MOD   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FRAC  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NMIN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOVF  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_FREQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R_COUNTER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLK_DIV    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_CLK   = 3'd7;

  localparam logic [WIDX_W-1:0] WIDX_FIRST = 3'd5;
  localparam logic [WIDX_W-1:0] WIDX_LAST  = 3'd0;

  typedef enum logic [3:0] {
    S_IDLE, S_SEL, S_M1, S_D1, S_M2, S_D2, S_M3, S_D3,
    S_G, S_D4, S_D5, S_CAP, S_WAIT, S_CHECK, S_EMIT
  } state_t;

endpackage

// ===== design/fpr_in_if.sv =====
interface fpr_in_if;
  logic                        valid;
  logic                        ready;
  logic [fpr_pkg::FREQ_W-1:0]  target_freq;
  modport source (output valid, output target_freq, input ready);
  modport sink (input valid, input target_freq, output ready);
endinterface

// ===== design/fpr_out_if.sv =====
interface fpr_out_if;
  logic                          valid;
  logic                          ready;
  logic [fpr_pkg::STATUS_W-1:0]  status;
  logic [fpr_pkg::WIDX_W-1:0]    word_index;
  logic [fpr_pkg::WORD_W-1:0]    reg_word;
  logic                          last;
  modport source (output valid, output status, output word_index, output reg_word,
                  output last, input ready);
  modport sink (input valid, input status, input word_index, input reg_word,
                input last, output ready);
endinterface

// ===== design/fpr_cfg_if.sv =====
interface fpr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpr_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [fpr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

// ===== design/frac_n_pll_register_calc.sv =====
// fractional-N synthesizer register calculator
// in_ch carries one target frequency in Hz per item (valid/ready, taken when both
// are high). cfg_ch writes the eight setup registers by index; write them only
// while the block is idle. cfg_ch is always ready.
// out_ch returns six control words per item, word_index 5 down to 0, last on
// word 0, status 0. On a failed check a single item comes out instead, with the
// status code, word_index 0, reg_word 0 and last set.
// One item is processed at a time; in_ch is ready only while idle.
// The time from accept to the first word is set by the shared bit-serial divider
// (three divisions per item, two more when frac and modulus share a factor),
// the binary gcd unit and the shift-add multiplier (one multiplier bit a cycle).
// A too-low target is rejected in the cycle after accept.
// When the receiver stalls the current word is held and no new item is taken.
// Synchronous reset returns to idle and loads the default register values.
module frac_n_pll_register_calc #(
  parameter logic [fpr_pkg::FREQ_W-1:0] MIN_FREQ = fpr_pkg::MIN_FREQ_DEF
) (
  input logic       clk,
  input logic       rst_n,
  fpr_in_if.sink    in_ch,
  fpr_out_if.source out_ch,
  fpr_cfg_if.sink   cfg_ch
);

  localparam int VW = fpr_pkg::VAL_W;

  // configuration
  logic [27:0] ref_freq_r;
  logic [9:0]  r_counter_r;
  logic        ref_doubler_r;
  logic        ref_div2_r;
  logic [23:0] chan_step_r;
  logic [11:0] clk_div_r;
  logic [1:0]  power_level_r;
  logic [7:0]  band_sel_clock_r;

  fpr_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [fpr_pkg::FREQ_W-1:0]   freq_r;
  logic [2:0]                   sel_r;
  logic                         presc_r;
  logic [fpr_pkg::PN_W-1:0]     pn_r;
  logic [fpr_pkg::PD_W-1:0]     pd_r;
  logic [fpr_pkg::NINT_W-1:0]   nint_r;
  logic [VW-1:0]                rem_r;
  logic [VW-1:0]                mod_r;
  logic [VW-1:0]                frac_r;
  logic [fpr_pkg::STATUS_W-1:0] err_r;
  logic [fpr_pkg::WIDX_W-1:0]   idx_r;

  logic                         in_acc, out_acc;
  logic                         too_low, sel_go, zero_cfg, skip_gcd, g_one;
  logic [fpr_pkg::FS_W-1:0]     fs;
  logic [fpr_pkg::STATUS_W-1:0] chk;
  logic [9:0]                   rr;

  logic                         mul_start, mul_done;
  logic [fpr_pkg::MUL_AW-1:0]   mul_a, mul_p;
  logic [fpr_pkg::MUL_BW-1:0]   mul_b;
  logic                         div_start, div_done;
  logic [fpr_pkg::DIV_NW-1:0]   div_n, div_q;
  logic [fpr_pkg::DIV_DW-1:0]   div_d, div_r;
  logic                         gcd_start, gcd_done;
  logic [fpr_pkg::GCD_W-1:0]    gcd_g;

  logic [fpr_pkg::WORD_W-1:0]   word;
  logic                         fz;

  fpr_mul #(.AW(fpr_pkg::MUL_AW), .BW(fpr_pkg::MUL_BW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  fpr_div #(.NW(fpr_pkg::DIV_NW), .DW(fpr_pkg::DIV_DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  fpr_gcd #(.W(fpr_pkg::GCD_W)) u_gcd (
    .clk(clk), .rst_n(rst_n), .start(gcd_start), .a(div_q[VW-1:0]), .b(mod_r),
    .done(gcd_done), .g(gcd_g)
  );

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_freq_r       <= 28'd25000000;
      r_counter_r      <= 10'd1;
      ref_doubler_r    <= 1'b0;
      ref_div2_r       <= 1'b0;
      chan_step_r      <= 24'd100000;
      clk_div_r        <= 12'd150;
      power_level_r    <= 2'd3;
      band_sel_clock_r <= 8'd200;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        fpr_pkg::CFG_REF_FREQ:  ref_freq_r       <= cfg_ch.data;
        fpr_pkg::CFG_R_COUNTER: r_counter_r      <= cfg_ch.data[9:0];
        fpr_pkg::CFG_DOUBLER:   ref_doubler_r    <= cfg_ch.data[0];
        fpr_pkg::CFG_DIV2:      ref_div2_r       <= cfg_ch.data[0];
        fpr_pkg::CFG_CHAN_STEP: chan_step_r      <= cfg_ch.data[23:0];
        fpr_pkg::CFG_CLK_DIV:   clk_div_r        <= cfg_ch.data[11:0];
        fpr_pkg::CFG_POWER:     power_level_r    <= cfg_ch.data[1:0];
        fpr_pkg::CFG_BAND_CLK:  band_sel_clock_r <= cfg_ch.data[7:0];
      endcase
    end
  end

  assign rr       = (r_counter_r == '0) ? 10'd1 : r_counter_r;
  assign too_low  = in_ch.target_freq < MIN_FREQ;
  assign fs       = fpr_pkg::FS_W'(freq_r) << sel_r;
  assign sel_go   = (fs <= fpr_pkg::LO_RATIO) && (sel_r <= fpr_pkg::SEL_MAX);
  assign zero_cfg = (pn_r == '0) || (chan_step_r == '0);
  assign skip_gcd = (div_q[VW-1:0] == '0) || (mod_r == '0);
  assign g_one    = gcd_g == fpr_pkg::GCD_W'(1);

  // checks in priority order
  always_comb begin
    if (mod_r < fpr_pkg::MOD_MIN || mod_r > fpr_pkg::MOD_MAX) chk = fpr_pkg::ST_MOD;
    else if (frac_r >= mod_r) chk = fpr_pkg::ST_FRAC;
    else if (nint_r > fpr_pkg::N_MAX) chk = fpr_pkg::ST_NOVF;
    else if (presc_r ? (nint_r < fpr_pkg::N_MIN_P1) : (nint_r < fpr_pkg::N_MIN_P0))
      chk = fpr_pkg::ST_NMIN;
    else chk = fpr_pkg::ST_OK;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      fpr_pkg::S_IDLE: if (in_acc) state_nxt = too_low ? fpr_pkg::S_EMIT : fpr_pkg::S_SEL;
      fpr_pkg::S_SEL: begin
        if (!sel_go) state_nxt = zero_cfg ? fpr_pkg::S_EMIT : fpr_pkg::S_M1;
      end
      fpr_pkg::S_M1: begin state_nxt = fpr_pkg::S_WAIT; ret_nxt = fpr_pkg::S_D1; end
      fpr_pkg::S_D1: begin state_nxt = fpr_pkg::S_WAIT; ret_nxt = fpr_pkg::S_M2; end
      fpr_pkg::S_M2: begin state_nxt = fpr_pkg::S_WAIT; ret_nxt = fpr_pkg::S_D2; end
      fpr_pkg::S_D2: begin state_nxt = fpr_pkg::S_WAIT; ret_nxt = fpr_pkg::S_M3; end
      fpr_pkg::S_M3: begin state_nxt = fpr_pkg::S_WAIT; ret_nxt = fpr_pkg::S_D3; end
      fpr_pkg::S_D3: begin state_nxt = fpr_pkg::S_WAIT; ret_nxt = fpr_pkg::S_G; end
      fpr_pkg::S_G: begin
        if (skip_gcd) state_nxt = fpr_pkg::S_CHECK;
        else begin
          state_nxt = fpr_pkg::S_WAIT;
          ret_nxt   = fpr_pkg::S_D4;
        end
      end
      fpr_pkg::S_D4: begin
        if (g_one) state_nxt = fpr_pkg::S_CHECK;
        else begin
          state_nxt = fpr_pkg::S_WAIT;
          ret_nxt   = fpr_pkg::S_D5;
        end
      end
      fpr_pkg::S_D5: begin state_nxt = fpr_pkg::S_WAIT; ret_nxt = fpr_pkg::S_CAP; end
      fpr_pkg::S_CAP: state_nxt = fpr_pkg::S_CHECK;
      fpr_pkg::S_WAIT: if (mul_done || div_done || gcd_done) state_nxt = ret_r;
      fpr_pkg::S_CHECK: state_nxt = fpr_pkg::S_EMIT;
      fpr_pkg::S_EMIT: if (out_acc && idx_r == fpr_pkg::WIDX_LAST) state_nxt = fpr_pkg::S_IDLE;
      default: state_nxt = fpr_pkg::S_IDLE;
    endcase
  end

  // control outputs and operand routing
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    gcd_start    = 1'b0;
    mul_a        = fpr_pkg::MUL_AW'(fs);
    mul_b        = fpr_pkg::MUL_BW'(pd_r);
    div_n        = mul_p;
    div_d        = fpr_pkg::DIV_DW'(pn_r);
    unique case (state_r)
      fpr_pkg::S_IDLE: in_ch.ready = 1'b1;
      fpr_pkg::S_EMIT: out_ch.valid = 1'b1;
      fpr_pkg::S_M1: mul_start = 1'b1;
      fpr_pkg::S_D1: div_start = 1'b1;
      fpr_pkg::S_M2: begin
        mul_start = 1'b1;
        mul_a     = fpr_pkg::MUL_AW'(chan_step_r);
      end
      fpr_pkg::S_D2: begin
        div_start = 1'b1;
        div_n     = fpr_pkg::DIV_NW'(pn_r);
        div_d     = mul_p[fpr_pkg::DIV_DW-1:0];
      end
      fpr_pkg::S_M3: begin
        mul_start = 1'b1;
        mul_a     = fpr_pkg::MUL_AW'(rem_r);
        mul_b     = fpr_pkg::MUL_BW'(div_q[VW-1:0]);
      end
      fpr_pkg::S_D3: begin
        // frac = (2*rem*mod + pn) / (2*pn)
        div_start = 1'b1;
        div_n     = {mul_p[fpr_pkg::MUL_AW-2:0], 1'b0} + fpr_pkg::DIV_NW'(pn_r);
        div_d     = fpr_pkg::DIV_DW'({pn_r, 1'b0});
      end
      fpr_pkg::S_G: gcd_start = !skip_gcd;
      fpr_pkg::S_D4: begin
        div_start = !g_one;
        div_n     = fpr_pkg::DIV_NW'(frac_r);
        div_d     = fpr_pkg::DIV_DW'(gcd_g);
      end
      fpr_pkg::S_D5: begin
        div_start = 1'b1;
        div_n     = fpr_pkg::DIV_NW'(mod_r);
        div_d     = fpr_pkg::DIV_DW'(gcd_g);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpr_pkg::S_IDLE;
      ret_r   <= fpr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    case (state_r)
      fpr_pkg::S_IDLE: begin
        freq_r <= in_ch.target_freq;
        sel_r  <= '0;
        pn_r   <= ref_doubler_r ? {ref_freq_r, 1'b0} : {1'b0, ref_freq_r};
        pd_r   <= ref_div2_r ? {rr, 1'b0} : {1'b0, rr};
        err_r  <= fpr_pkg::ST_LOW;
        idx_r  <= fpr_pkg::WIDX_LAST;
      end
      fpr_pkg::S_SEL: begin
        if (sel_go) sel_r <= sel_r + 1'b1;
        presc_r <= fs > fpr_pkg::PRESCALE_LIM;
        err_r   <= fpr_pkg::ST_MOD;
      end
      fpr_pkg::S_M2: begin
        nint_r <= div_q[fpr_pkg::NINT_W-1:0];
        rem_r  <= div_r[VW-1:0];
      end
      fpr_pkg::S_M3:  mod_r  <= div_q[VW-1:0];
      fpr_pkg::S_G:   frac_r <= div_q[VW-1:0];
      fpr_pkg::S_D5:  frac_r <= div_q[VW-1:0];
      fpr_pkg::S_CAP: mod_r  <= div_q[VW-1:0];
      fpr_pkg::S_CHECK: begin
        err_r <= chk;
        idx_r <= (chk == fpr_pkg::ST_OK) ? fpr_pkg::WIDX_FIRST : fpr_pkg::WIDX_LAST;
      end
      fpr_pkg::S_EMIT: if (out_acc && idx_r != fpr_pkg::WIDX_LAST) idx_r <= idx_r - 1'b1;
      default: ;
    endcase
  end

  assign fz = frac_r == '0;

  always_comb begin
    case (idx_r)
      3'd0: word = {1'b0, nint_r[15:0], frac_r[11:0], 3'd0};
      3'd1: word = 32'd1 | (32'(mod_r[11:0]) << 3) | (32'd1 << 15) | (32'(presc_r) << 27);
      3'd2: word = 32'd2 | (32'd1 << 6) | (32'd7 << 9) | (32'(r_counter_r) << 14)
                 | (32'(ref_div2_r) << 24) | (32'(ref_doubler_r) << 25)
                 | (fz ? (32'd3 << 7) : 32'd0);
      3'd3: word = 32'd3 | (32'(clk_div_r) << 3) | (32'd1 << 23)
                 | (fz ? (32'd3 << 21) : 32'd0);
      3'd4: word = 32'd4 | (32'(power_level_r) << 3) | (32'd1 << 5)
                 | (32'(band_sel_clock_r) << 12) | (32'(sel_r) << 20) | (32'd1 << 23);
      3'd5: word = 32'd5 | (32'd3 << 19) | (32'd1 << 22);
      default: word = '0;
    endcase
  end

  assign out_ch.status     = err_r;
  assign out_ch.word_index = idx_r;
  assign out_ch.reg_word   = (err_r == fpr_pkg::ST_OK) ? word : '0;
  assign out_ch.last       = idx_r == fpr_pkg::WIDX_LAST;

endmodule

// ===== design/fpr_mul.sv =====
module fpr_mul #(
  parameter int AW = fpr_pkg::MUL_AW,
  parameter int BW = fpr_pkg::MUL_BW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [AW-1:0] prod
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [AW-1:0] acc_r, acc_nxt;

  // shift-add, one multiplier bit a cycle, stops once the remaining bits are zero
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt = {a_r[AW-2:0], 1'b0};
        b_nxt = {1'b0, b_r[BW-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== design/fpr_div.sv =====
module fpr_div #(
  parameter int NW = fpr_pkg::DIV_NW,
  parameter int DW = fpr_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit a cycle
  assign trial = {r_r, q_r[NW-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[NW-2:0], ge};
      r_nxt   = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== design/fpr_gcd.sv =====
module fpr_gcd #(
  parameter int W = fpr_pkg::GCD_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] g
);

  localparam int KW = $clog2(W) + 1;

  logic          busy_r, busy_nxt;
  logic          fix_r, fix_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [KW-1:0] k_r, k_nxt;

  // binary gcd on nonzero operands, then put the common twos back one a cycle
  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = fix_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      fix_nxt  = 1'b0;
      a_nxt    = a;
      b_nxt    = b;
      k_nxt    = '0;
    end else if (busy_r && !fix_r) begin
      if (a_r == b_r) begin
        fix_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r > b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end else if (busy_r) begin
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        a_nxt = {a_r[W-2:0], 1'b0};
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

  assign done = done_r;
  assign g    = a_r;

endmodule

// ===== tb/frac_n_pll_register_calc_tb.sv =====
module frac_n_pll_register_calc_tb;

  typedef struct packed {
    logic [fpr_pkg::STATUS_W-1:0] status;
    logic [fpr_pkg::WIDX_W-1:0]   word_index;
    logic [fpr_pkg::WORD_W-1:0]   reg_word;
    logic                         last;
  } ctrl_word_t;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  int unsigned cyc = 0;
  int unsigned mismatches = 0;

  fpr_in_if  in_ch ();
  fpr_out_if out_ch ();
  fpr_cfg_if cfg_ch ();

  frac_n_pll_register_calc dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // local copy of the setup registers
  longint unsigned ref_hz, r_div, dbl, half, step_hz, clkdiv, pwr, band_clk;

  logic [fpr_pkg::FREQ_W-1:0] freq_q[$];
  ctrl_word_t                 word_q[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit idle_now();
    // quiet window with no idling at all
    if ((cyc % 4000) >= 3000) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  function automatic void push_status(input logic [fpr_pkg::STATUS_W-1:0] st);
    ctrl_word_t e;
    e.status = st;
    e.word_index = fpr_pkg::WIDX_LAST;
    e.reg_word = '0;
    e.last = 1'b1;
    word_q.push_back(e);
  endfunction

  function automatic void predict_words(input logic [fpr_pkg::FREQ_W-1:0] f);
    longint unsigned fr, ratio, odiv, sel, presc, rr, pn, pd, num, nint, rem, md, fc;
    longint unsigned a, b, t;
    logic [31:0] w[6];
    ctrl_word_t e;
    fr = f;
    if (fr < fpr_pkg::MIN_FREQ_DEF) begin
      push_status(fpr_pkg::ST_LOW);
      return;
    end
    ratio = 64'd2200000000 / fr;
    odiv = 1;
    sel = 0;
    while (odiv <= ratio && odiv <= 64) begin
      odiv = odiv << 1;
      sel++;
    end
    presc = (fr > 64'd3600000000 / odiv) ? 1 : 0;
    rr = (r_div == 0) ? 1 : r_div;
    pn = ref_hz * (1 + dbl);
    pd = rr * (1 + half);
    if (pn == 0 || step_hz == 0) begin
      push_status(fpr_pkg::ST_MOD);
      return;
    end
    num = fr * odiv * pd;
    nint = num / pn;
    rem = num % pn;
    md = pn / (pd * step_hz);
    fc = (2 * rem * md + pn) / (2 * pn);
    if (fc != 0 && md != 0) begin
      a = fc;
      b = md;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      if (a > 1) begin
        fc = fc / a;
        md = md / a;
      end
    end
    if (md < 2 || md > 4095) begin
      push_status(fpr_pkg::ST_MOD);
      return;
    end
    if (fc >= md) begin
      push_status(fpr_pkg::ST_FRAC);
      return;
    end
    if (nint > 65535) begin
      push_status(fpr_pkg::ST_NOVF);
      return;
    end
    if ((presc == 0 && nint < 23) || (presc == 1 && nint < 75)) begin
      push_status(fpr_pkg::ST_NMIN);
      return;
    end
    w[0] = {nint[16:0], fc[11:0], 3'd0};
    w[1] = 32'd1 | (32'(md[11:0]) << 3) | (32'd1 << 15) | (32'(presc) << 27);
    w[2] = 32'd2 | (32'd1 << 6) | (32'd7 << 9) | (32'(r_div[9:0]) << 14)
         | (32'(half) << 24) | (32'(dbl) << 25);
    w[3] = 32'd3 | (32'(clkdiv[11:0]) << 3) | (32'd1 << 23);
    if (fc == 0) begin
      w[2] = w[2] | (32'd3 << 7);
      w[3] = w[3] | (32'd3 << 21);
    end
    w[4] = 32'd4 | (32'(pwr[1:0]) << 3) | (32'd1 << 5) | (32'(band_clk[7:0]) << 12)
         | (32'(sel[2:0]) << 20) | (32'd1 << 23);
    w[5] = 32'd5 | (32'd3 << 19) | (32'd1 << 22);
    for (int k = 5; k >= 0; k--) begin
      e.status = fpr_pkg::ST_OK;
      e.word_index = fpr_pkg::WIDX_W'(k);
      e.reg_word = w[k];
      e.last = (k == 0);
      word_q.push_back(e);
    end
  endfunction

  function automatic logic [fpr_pkg::FREQ_W-1:0] rand_freq();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(fpr_pkg::MIN_FREQ_DEF - 1, 0);
    if (r < 20) return $urandom();
    return $urandom_range(32'hFFFF_FFFF, fpr_pkg::MIN_FREQ_DEF);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.target_freq <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_words(in_ch.target_freq);
      if (!in_ch.valid || in_ch.ready) begin
        if (freq_q.size() != 0 && !idle_now()) begin
          in_ch.valid <= 1'b1;
          in_ch.target_freq <= freq_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    ctrl_word_t exp_w;
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_now();
      if (out_ch.valid && out_ch.ready) begin
        if (word_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: status %0d idx %0d word %h last %0b",
                     out_ch.status, out_ch.word_index, out_ch.reg_word, out_ch.last);
        end else begin
          exp_w = word_q.pop_front();
          if (out_ch.status !== exp_w.status || out_ch.word_index !== exp_w.word_index ||
              out_ch.reg_word !== exp_w.reg_word || out_ch.last !== exp_w.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp st %0d idx %0d word %h last %0b,",
                        " got st %0d idx %0d word %h last %0b"},
                       exp_w.status, exp_w.word_index, exp_w.reg_word, exp_w.last,
                       out_ch.status, out_ch.word_index, out_ch.reg_word, out_ch.last);
          end
        end
      end
    end
  end

  task automatic cfg_write(input logic [fpr_pkg::CFG_IDX_W-1:0] idx,
                           input longint unsigned val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data <= fpr_pkg::CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      fpr_pkg::CFG_REF_FREQ:  ref_hz = val & 64'hFFF_FFFF;
      fpr_pkg::CFG_R_COUNTER: r_div = val & 64'h3FF;
      fpr_pkg::CFG_DOUBLER:   dbl = val & 1;
      fpr_pkg::CFG_DIV2:      half = val & 1;
      fpr_pkg::CFG_CHAN_STEP: step_hz = val & 64'hFF_FFFF;
      fpr_pkg::CFG_CLK_DIV:   clkdiv = val & 64'hFFF;
      fpr_pkg::CFG_POWER:     pwr = val & 3;
      fpr_pkg::CFG_BAND_CLK:  band_clk = val & 64'hFF;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_all(input longint unsigned rf, r, d, t, st, cd, p, bc);
    cfg_write(fpr_pkg::CFG_REF_FREQ, rf);
    cfg_write(fpr_pkg::CFG_R_COUNTER, r);
    cfg_write(fpr_pkg::CFG_DOUBLER, d);
    cfg_write(fpr_pkg::CFG_DIV2, t);
    cfg_write(fpr_pkg::CFG_CHAN_STEP, st);
    cfg_write(fpr_pkg::CFG_CLK_DIV, cd);
    cfg_write(fpr_pkg::CFG_POWER, p);
    cfg_write(fpr_pkg::CFG_BAND_CLK, bc);
  endtask

  task automatic run_items(input int n);
    for (int i = 0; i < n; i++) freq_q.push_back(rand_freq());
    wait (freq_q.size() == 0 && !in_ch.valid && word_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    longint unsigned rf, r, d, t, pn, pd;
    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.data = '0;
    ref_hz = 25000000; r_div = 1; dbl = 0; half = 0;
    step_hz = 100000; clkdiv = 150; pwr = 3; band_clk = 200;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes of the target, divider edges, integer-N
    freq_q = '{32'd0, fpr_pkg::MIN_FREQ_DEF - 1, fpr_pkg::MIN_FREQ_DEF, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'd2200000000, 32'd2199999999,
               32'd1100000000, 32'd3600000000, 32'd3600000001, 32'd1800000001,
               32'd2400000000, 32'd2400050000, 32'd2400012345, 32'd68750000,
               32'd34375000, 32'd137500000, 32'd1099999999, 32'd1, 32'h5555_5555,
               32'hAAAA_AAAA};
    run_items(40);

    // highest reference with doubler, widest step: small N, reduced fractions
    set_all(250000000, 1, 1, 0, 16777215, 4095, 0, 255);
    freq_q = '{fpr_pkg::MIN_FREQ_DEF, 32'd4000000000, 32'd3600000000};
    run_items(20);
    // lowest reference, largest R: N overflow and tiny modulus
    set_all(100000, 1023, 0, 1, 1, 0, 1, 0);
    run_items(20);
    // zero R counter, step too fine for the modulus range
    set_all(26000000, 0, 1, 1, 1, 2048, 2, 1);
    run_items(15);
    // zero reference and zero channel step
    set_all(0, 5, 0, 0, 0, 1, 3, 128);
    run_items(8);
    cfg_write(fpr_pkg::CFG_REF_FREQ, 10000000);
    run_items(8);

    // random settings aimed at a legal modulus
    for (int ph = 0; ph < 4; ph++) begin
      rf = $urandom_range(250000000, 100000);
      r = $urandom_range(8, 1);
      d = $urandom_range(1);
      t = $urandom_range(1);
      pn = rf * (1 + d);
      pd = r * (1 + t);
      set_all(rf, r, d, t, 1, $urandom_range(4095), $urandom_range(3), $urandom_range(255));
      rf = pn / (pd * $urandom_range(4095, 2));
      cfg_write(fpr_pkg::CFG_CHAN_STEP, (rf == 0) ? 1 : rf);
      run_items(40);
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== frac_n_pll_register_calc.f =====
design/fpr_pkg.sv
design/fpr_in_if.sv
design/fpr_out_if.sv
design/fpr_cfg_if.sv
design/fpr_mul.sv
design/fpr_div.sv
design/fpr_gcd.sv
design/frac_n_pll_register_calc.sv
tb/frac_n_pll_register_calc_tb.sv
